@@ rtl/irc_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared codes, character constants, the result type and byte classifiers
// for the chat-line tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

    typedef logic [3:0] t_phase;

    localparam t_phase PH_START       = 4'd0;
    localparam t_phase PH_KEY         = 4'd1;
    localparam t_phase PH_VAL_FIRST   = 4'd2;
    localparam t_phase PH_VAL         = 4'd3;
    localparam t_phase PH_TAGSP       = 4'd4;
    localparam t_phase PH_PRE_FIRST   = 4'd5;
    localparam t_phase PH_PRE         = 4'd6;
    localparam t_phase PH_CMD_FIRST   = 4'd7;
    localparam t_phase PH_CMD_ALPHA   = 4'd8;
    localparam t_phase PH_CMD_DIGIT   = 4'd9;
    localparam t_phase PH_CMD_AFTER   = 4'd10;
    localparam t_phase PH_PARAM_START = 4'd11;
    localparam t_phase PH_MID         = 4'd12;
    localparam t_phase PH_TRAIL_FIRST = 4'd13;
    localparam t_phase PH_TRAIL       = 4'd14;
    localparam t_phase PH_DONE        = 4'd15;

    localparam logic [2:0] SEG_KEY     = 3'd0;
    localparam logic [2:0] SEG_VALUE   = 3'd1;
    localparam logic [2:0] SEG_PREFIX  = 3'd2;
    localparam logic [2:0] SEG_COMMAND = 3'd3;
    localparam logic [2:0] SEG_MIDDLE  = 3'd4;
    localparam logic [2:0] SEG_TRAIL   = 3'd5;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EMPTY_KEY  = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd2;
    localparam logic [2:0] ERR_NO_SPACE   = 3'd3;
    localparam logic [2:0] ERR_BAD_CMD    = 3'd4;
    localparam logic [2:0] ERR_BAD_SEP    = 3'd5;
    localparam logic [2:0] ERR_NO_TRAIL   = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd7;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic [2:0] segment;
        logic [5:0] tag_number;
        logic [3:0] param_number;
        logic       token_start;
        logic       command_numeric;
        logic       message_end;
        logic [2:0] error_code;
    } t_result;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_term(input logic [7:0] b);
        return b == CH_CR || b == CH_LF || b == CH_NUL;
    endfunction

endpackage

@@ rtl/irc_tok_in_if.sv @@
// ----------------------------------------------------------------------------
// irc_tok_in_if
// Raw byte channel into the tokenizer: one line byte and its end mark a beat.
// ----------------------------------------------------------------------------
interface irc_tok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

@@ rtl/irc_tok_out_if.sv @@
// ----------------------------------------------------------------------------
// irc_tok_out_if
// Token channel out of the tokenizer: one decoded result a beat.
// ----------------------------------------------------------------------------
interface irc_tok_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic [2:0] segment;
    logic [5:0] tag_number;
    logic [3:0] param_number;
    logic       token_start;
    logic       command_numeric;
    logic       message_end;
    logic [2:0] error_code;

    modport source (output valid, output has_byte, output data_byte, output segment,
                    output tag_number, output param_number, output token_start,
                    output command_numeric, output message_end, output error_code,
                    input ready);
    modport sink   (input valid, input has_byte, input data_byte, input segment,
                    input tag_number, input param_number, input token_start,
                    input command_numeric, input message_end, input error_code,
                    output ready);
endinterface

@@ rtl/irc_tok_fsm.sv @@
// ----------------------------------------------------------------------------
// irc_tok_fsm
// Parser state and the single-byte step: decodes one byte per fire and
// produces at most one result.
// ----------------------------------------------------------------------------
module irc_tok_fsm #(
    parameter int MAX_TAGS   = 64,
    parameter int MAX_PARAMS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_res_valid,
    output irc_tok_pkg::t_result o_res
);

    localparam int TAG_W   = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int PARAM_W = $clog2(MAX_PARAMS);
    localparam logic [TAG_W-1:0]   TAG_TOP   = TAG_W'(MAX_TAGS - 1);
    localparam logic [PARAM_W-1:0] PARAM_TOP = PARAM_W'(MAX_PARAMS - 1);

    irc_tok_pkg::t_phase r_phase, n_phase;
    logic               r_esc, n_esc;
    logic               r_knz, n_knz;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [PARAM_W-1:0] r_param, n_param;
    logic [1:0]         r_dig, n_dig;
    logic [2:0]         r_err, n_err;

    logic       put_has;
    logic [7:0] put_data;
    logic [2:0] put_seg;
    logic       put_tok;
    logic [2:0] err_new;
    logic [7:0] esc_data;
    logic       esc_ok;
    logic [TAG_W+5:0]   tag_ext;
    logic [PARAM_W+3:0] param_ext;

    always_comb begin
        esc_ok   = 1'b1;
        esc_data = irc_tok_pkg::CH_NUL;
        case (i_byte)
            irc_tok_pkg::CH_COLON: esc_data = irc_tok_pkg::CH_SEMI;
            irc_tok_pkg::CH_S:     esc_data = irc_tok_pkg::CH_SPACE;
            irc_tok_pkg::CH_BSL:   esc_data = irc_tok_pkg::CH_BSL;
            irc_tok_pkg::CH_R:     esc_data = irc_tok_pkg::CH_CR;
            irc_tok_pkg::CH_N:     esc_data = irc_tok_pkg::CH_LF;
            default:               esc_ok   = 1'b0;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_knz    = r_knz;
        n_tag    = r_tag;
        n_param  = r_param;
        n_dig    = r_dig;
        put_has  = 1'b0;
        put_data = 8'd0;
        put_seg  = irc_tok_pkg::SEG_KEY;
        put_tok  = 1'b0;
        err_new  = irc_tok_pkg::ERR_NONE;

        if (r_err == irc_tok_pkg::ERR_NONE) begin
            case (r_phase)
                irc_tok_pkg::PH_START, irc_tok_pkg::PH_TAGSP,
                irc_tok_pkg::PH_CMD_FIRST: begin
                    if (r_phase == irc_tok_pkg::PH_START && i_byte == irc_tok_pkg::CH_AT) begin
                        n_phase = irc_tok_pkg::PH_KEY;
                        n_knz   = 1'b0;
                    end else if (r_phase == irc_tok_pkg::PH_TAGSP
                                 && i_byte == irc_tok_pkg::CH_SPACE) begin
                        n_phase = r_phase;
                    end else if (r_phase != irc_tok_pkg::PH_CMD_FIRST
                                 && i_byte == irc_tok_pkg::CH_COLON) begin
                        n_phase = irc_tok_pkg::PH_PRE_FIRST;
                    end else if (irc_tok_pkg::is_alpha(i_byte)) begin
                        n_phase = irc_tok_pkg::PH_CMD_ALPHA;
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_COMMAND; put_tok = 1'b1;
                    end else if (irc_tok_pkg::is_digit(i_byte)) begin
                        n_phase = irc_tok_pkg::PH_CMD_DIGIT;
                        n_dig   = 2'd1;
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_COMMAND; put_tok = 1'b1;
                    end else begin
                        err_new = irc_tok_pkg::ERR_BAD_CMD;
                    end
                end
                irc_tok_pkg::PH_KEY: begin
                    if (irc_tok_pkg::is_alpha(i_byte) || irc_tok_pkg::is_digit(i_byte)
                        || i_byte == irc_tok_pkg::CH_MINUS || i_byte == irc_tok_pkg::CH_SLASH
                        || i_byte == irc_tok_pkg::CH_PLUS) begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_KEY; put_tok = !r_knz;
                        n_knz   = 1'b1;
                    end else if (!r_knz) begin
                        err_new = irc_tok_pkg::ERR_EMPTY_KEY;
                    end else if (i_byte == irc_tok_pkg::CH_EQ) begin
                        n_phase = irc_tok_pkg::PH_VAL_FIRST;
                    end else if (i_byte == irc_tok_pkg::CH_SEMI) begin
                        if (r_tag < TAG_TOP) n_tag = r_tag + 1'b1;
                        n_knz = 1'b0;
                    end else if (i_byte == irc_tok_pkg::CH_SPACE) begin
                        n_phase = irc_tok_pkg::PH_TAGSP;
                    end else begin
                        err_new = irc_tok_pkg::ERR_NO_SPACE;
                    end
                end
                irc_tok_pkg::PH_VAL_FIRST, irc_tok_pkg::PH_VAL: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (esc_ok) begin
                            put_has = 1'b1; put_data = esc_data;
                            put_seg = irc_tok_pkg::SEG_VALUE;
                            put_tok = (r_phase == irc_tok_pkg::PH_VAL_FIRST);
                            n_phase = irc_tok_pkg::PH_VAL;
                        end else begin
                            err_new = irc_tok_pkg::ERR_BAD_ESC;
                        end
                    end else if (i_byte == irc_tok_pkg::CH_SEMI) begin
                        if (r_tag < TAG_TOP) n_tag = r_tag + 1'b1;
                        n_knz   = 1'b0;
                        n_phase = irc_tok_pkg::PH_KEY;
                    end else if (i_byte == irc_tok_pkg::CH_SPACE) begin
                        n_phase = irc_tok_pkg::PH_TAGSP;
                    end else if (irc_tok_pkg::is_term(i_byte)) begin
                        err_new = irc_tok_pkg::ERR_NO_SPACE;
                    end else if (i_byte == irc_tok_pkg::CH_BSL) begin
                        n_esc = 1'b1;
                    end else begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_VALUE;
                        put_tok = (r_phase == irc_tok_pkg::PH_VAL_FIRST);
                        n_phase = irc_tok_pkg::PH_VAL;
                    end
                end
                irc_tok_pkg::PH_PRE_FIRST, irc_tok_pkg::PH_PRE: begin
                    if (i_byte == irc_tok_pkg::CH_SPACE) begin
                        n_phase = irc_tok_pkg::PH_CMD_FIRST;
                    end else begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_PREFIX;
                        put_tok = (r_phase == irc_tok_pkg::PH_PRE_FIRST);
                        n_phase = irc_tok_pkg::PH_PRE;
                    end
                end
                irc_tok_pkg::PH_CMD_DIGIT: begin
                    if (!irc_tok_pkg::is_digit(i_byte)) begin
                        err_new = irc_tok_pkg::ERR_BAD_CMD;
                    end else begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_COMMAND;
                        n_dig   = r_dig + 2'd1;
                        // third digit closes the numeric command
                        if (r_dig == 2'd2) n_phase = irc_tok_pkg::PH_CMD_AFTER;
                    end
                end
                irc_tok_pkg::PH_CMD_ALPHA: begin
                    if (irc_tok_pkg::is_alpha(i_byte)) begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_COMMAND;
                    end else if (i_byte == irc_tok_pkg::CH_SPACE) begin
                        n_phase = irc_tok_pkg::PH_PARAM_START;
                    end else begin
                        n_phase = irc_tok_pkg::PH_DONE;
                    end
                end
                irc_tok_pkg::PH_CMD_AFTER: begin
                    n_phase = (i_byte == irc_tok_pkg::CH_SPACE) ?
                              irc_tok_pkg::PH_PARAM_START : irc_tok_pkg::PH_DONE;
                end
                irc_tok_pkg::PH_PARAM_START: begin
                    if (i_byte == irc_tok_pkg::CH_COLON) begin
                        n_phase = irc_tok_pkg::PH_TRAIL_FIRST;
                    end else if (irc_tok_pkg::is_term(i_byte)) begin
                        err_new = irc_tok_pkg::ERR_NO_TRAIL;
                    end else if (i_byte == irc_tok_pkg::CH_SPACE) begin
                        // empty middle param: counted, nothing emitted
                        if (r_param < PARAM_TOP) n_param = r_param + 1'b1;
                    end else begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_MIDDLE; put_tok = 1'b1;
                        n_phase = irc_tok_pkg::PH_MID;
                    end
                end
                irc_tok_pkg::PH_MID: begin
                    if (i_byte == irc_tok_pkg::CH_SPACE) begin
                        if (r_param < PARAM_TOP) n_param = r_param + 1'b1;
                        n_phase = irc_tok_pkg::PH_PARAM_START;
                    end else if (irc_tok_pkg::is_term(i_byte)) begin
                        err_new = irc_tok_pkg::ERR_BAD_SEP;
                    end else begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_MIDDLE;
                    end
                end
                irc_tok_pkg::PH_TRAIL_FIRST, irc_tok_pkg::PH_TRAIL: begin
                    if (irc_tok_pkg::is_term(i_byte)) begin
                        n_phase = irc_tok_pkg::PH_DONE;
                    end else begin
                        put_has = 1'b1; put_data = i_byte;
                        put_seg = irc_tok_pkg::SEG_TRAIL;
                        put_tok = (r_phase == irc_tok_pkg::PH_TRAIL_FIRST);
                        n_phase = irc_tok_pkg::PH_TRAIL;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        n_err = r_err;
        if (err_new != irc_tok_pkg::ERR_NONE) begin
            n_err    = err_new;
            put_has  = 1'b0;
            put_data = 8'd0;
            put_seg  = irc_tok_pkg::SEG_KEY;
            put_tok  = 1'b0;
        end
        if (i_last && n_err == irc_tok_pkg::ERR_NONE
            && n_phase != irc_tok_pkg::PH_TRAIL_FIRST && n_phase != irc_tok_pkg::PH_TRAIL
            && n_phase != irc_tok_pkg::PH_DONE) begin
            n_err = irc_tok_pkg::ERR_TRUNCATED;
        end
    end

    assign tag_ext   = {6'd0, n_tag};
    assign param_ext = {4'd0, n_param};

    assign o_res_valid = put_has || (err_new != irc_tok_pkg::ERR_NONE) || i_last;

    always_comb begin
        o_res.has_byte        = put_has;
        o_res.data_byte       = put_data;
        o_res.segment         = put_seg;
        o_res.tag_number      = tag_ext[5:0];
        o_res.param_number    = param_ext[3:0];
        o_res.token_start     = put_tok;
        o_res.command_numeric = (n_dig != 2'd0);
        o_res.message_end     = i_last;
        o_res.error_code      = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase <= irc_tok_pkg::PH_START;
            r_esc   <= 1'b0;
            r_knz   <= 1'b0;
            r_tag   <= '0;
            r_param <= '0;
            r_dig   <= 2'd0;
            r_err   <= irc_tok_pkg::ERR_NONE;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_knz   <= n_knz;
            r_tag   <= n_tag;
            r_param <= n_param;
            r_dig   <= n_dig;
            r_err   <= n_err;
        end
    end

endmodule

@@ rtl/irc_tok_outreg.sv @@
// ----------------------------------------------------------------------------
// irc_tok_outreg
// Result register driving the token channel; reloads in the cycle its beat
// is taken.
// ----------------------------------------------------------------------------
module irc_tok_outreg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_res_valid,
    input  irc_tok_pkg::t_result i_res,
    output logic                 o_can_load,
    irc_tok_out_if.source        o_out
);

    logic                 r_valid;
    irc_tok_pkg::t_result r_res;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.has_byte        = r_res.has_byte;
    assign o_out.data_byte       = r_res.data_byte;
    assign o_out.segment         = r_res.segment;
    assign o_out.tag_number      = r_res.tag_number;
    assign o_out.param_number    = r_res.param_number;
    assign o_out.token_start     = r_res.token_start;
    assign o_out.command_numeric = r_res.command_numeric;
    assign o_out.message_end     = r_res.message_end;
    assign o_out.error_code      = r_res.error_code;

endmodule

@@ rtl/irc_message_tokenizer.sv @@
// ----------------------------------------------------------------------------
// irc_message_tokenizer
// Byte-serial tokenizer for one chat-protocol line with an optional tag list.
// ----------------------------------------------------------------------------
// Takes one raw line byte per clock while the output is drained and returns at
// most one token beat per byte: a decoded byte with its segment, tag/param index
// and start mark, an error beat when parsing first fails, and a beat for every
// last byte. A byte is held in an input register, decoded combinationally
// against the parser state and written to a result register; while the result
// register is stalled the byte waits in the input register. Bytes after an
// error or a terminator are absorbed without a beat until the last byte,
// which returns the parser to the start of a message.
module irc_message_tokenizer #(
    parameter int MAX_TAGS   = 64,
    parameter int MAX_PARAMS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irc_tok_in_if.sink    i_in,
    irc_tok_out_if.source o_out
);

    logic                 r_s0_valid;
    logic [7:0]           r_s0_byte;
    logic                 r_s0_last;
    logic                 can_load;
    logic                 fire;
    logic                 res_valid;
    irc_tok_pkg::t_result res;

    assign fire       = r_s0_valid && can_load;
    assign i_in.ready = !r_s0_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s0_byte <= i_in.byte_in;
            r_s0_last <= i_in.last_byte;
        end
    end

    irc_tok_fsm #(
        .MAX_TAGS   (MAX_TAGS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_s0_byte),
        .i_last      (r_s0_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    irc_tok_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (can_load),
        .o_out       (o_out)
    );

    // a held input beat must not change while the result side is stalled
    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && !can_load) |=> (r_s0_valid && $stable(r_s0_byte)
                                       && $stable(r_s0_last)))
        else $error("input stage changed while stalled");

    // beats without a decoded byte carry a clean payload
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_byte) |-> (o_out.data_byte == 8'd0
            && o_out.segment == irc_tok_pkg::SEG_KEY && !o_out.token_start))
        else $error("empty beat carries byte data");

    // a byte beat reports no failure, except a truncation raised on the last byte
    a_byte_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_byte) |->
            (o_out.error_code == irc_tok_pkg::ERR_NONE
             || (o_out.message_end && o_out.error_code == irc_tok_pkg::ERR_TRUNCATED)))
        else $error("byte beat with parse error");

endmodule
